FILE: rtl/fwrbk_pkg.sv
package fwrbk_pkg;

    localparam int P_DEPTH = 16;
    localparam int VAL_W   = 16;
    localparam int OCC_W   = 5;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [VAL_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] removed_value;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

endpackage

FILE: rtl/fwrbk_ctrl.sv
module fwrbk_ctrl
    import fwrbk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_ctrl.load = (r_state == S_IDLE) && start;
    assign o_ctrl.exec = (r_state == S_EXEC);

`ifndef NO_ASSERTIONS
    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> o_ctrl.exec)
        else $error("request taken without execute cycle");
    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.exec |=> !o_ctrl.exec)
        else $error("execute lasted more than one cycle");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_ctrl.load)
        else $error("request loaded while busy");
`endif

endmodule

FILE: rtl/fwrbk_datapath.sv
module fwrbk_datapath
    import fwrbk_pkg::*;
#(
    parameter int DEPTH = P_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    input  t_req     i_req,
    output logic     o_done,
    output t_rsp     o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] r_slots [DEPTH];
    logic [VAL_W-1:0] n_slots [DEPTH];
    logic [VAL_W-1:0] up_slots [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    t_req             r_req;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    logic             r_done;

    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] del_oh;
    logic [DEPTH-1:0] shift_mask;
    logic             full;
    logic             empty;
    logic             found;
    logic             push_ok;
    logic             del_en;

    // entry i takes its successor when shifting; the last keeps its own
    for (genvar g = 0; g < DEPTH; g++) begin : g_up
        if (g < DEPTH - 1) begin : g_mid
            assign up_slots[g] = r_slots[g+1];
        end else begin : g_last
            assign up_slots[g] = r_slots[g];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = (CW'(i) < r_count) && (r_slots[i] == r_req.item_value);
        end
    end

    assign first_hit = hit & (~hit + DEPTH'(1));
    assign found     = |hit;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);

    always_comb begin
        n_rsp         = '0;
        n_rsp.status  = STAT_OK;
        push_ok       = 1'b0;
        del_en        = 1'b0;
        del_oh        = '0;
        case (r_req.cmd)
            CMD_PUSH: begin
                if (full) n_rsp.status = STAT_FULL;
                else      push_ok      = 1'b1;
            end
            CMD_POP: begin
                if (empty) begin
                    n_rsp.status = STAT_EMPTY;
                end else begin
                    del_en              = 1'b1;
                    del_oh              = DEPTH'(1);
                    n_rsp.removed_value = r_slots[0];
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    n_rsp.status = STAT_EMPTY;
                end else if (!found) begin
                    n_rsp.status = STAT_NOT_FOUND;
                end else begin
                    del_en              = 1'b1;
                    del_oh              = first_hit;
                    n_rsp.removed_value = r_req.item_value;
                end
            end
            default: begin
                n_rsp.status = STAT_OK;
            end
        endcase
        n_count = r_count;
        if (push_ok)     n_count = r_count + CW'(1);
        else if (del_en) n_count = r_count - CW'(1);
        n_rsp.occupancy = OCC_W'(n_count);
    end

    // every slot at or after the deleted one moves forward
    assign shift_mask = ~(del_oh - DEPTH'(1));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_slots[i] = r_slots[i];
            if (push_ok && (CW'(i) == r_count)) begin
                n_slots[i] = r_req.item_value;
            end else if (del_en && shift_mask[i]) begin
                n_slots[i] = up_slots[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) r_req <= i_req;
        if (i_ctrl.exec) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < DEPTH; i++) begin
                r_slots[i] <= n_slots[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_ctrl.exec;
            if (i_ctrl.exec) r_count <= n_count;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.exec |=> o_done)
        else $error("no result after execute");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.exec && push_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");
    a_single_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.exec |-> $onehot0(del_oh))
        else $error("more than one entry selected for delete");
`endif

endmodule

FILE: rtl/fifo_with_remove_by_key_unit.sv
// A taken request is registered, then evaluated in the execute state; the result
// strobe o_done is registered from that state; no new request is taken while busy.
// All slots are compared, deleted and shifted in execute; the FSM then goes idle.
// Reset (synchronous, active low) empties the queue and clears busy and o_done;
// slot contents are not cleared. Results cannot be stalled by the receiver.
module fifo_with_remove_by_key_unit
    import fwrbk_pkg::*;
#(
    parameter int DEPTH = P_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_dp_ctrl ctrl;

    fwrbk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (ctrl)
    );

    fwrbk_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule
